@@ design/gda_pkg.sv @@
`timescale 1ns / 1ps

package gda_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_MANY = 2'd1,
    STAT_BAD_DATE = 2'd2
  } stat_t;

  localparam logic [8:0] MAX_DAYS_RESET = 9'd300;
  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
  localparam logic [3:0] MONTH_FEB = 4'd2;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic step_final;
  } sts_t;

  // length of month m; 0 for a month code that means nothing
  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] n;
    n = 5'd0;
    if (m >= 4'd1 && m <= MONTHS_PER_YEAR) begin
      n = MONTH_DAYS[m - 4'd1];
    end
    if (m == MONTH_FEB && leap) begin
      n = FEB_LEAP_DAYS;
    end
    return n;
  endfunction

endpackage

@@ design/gda_ctrl.sv @@
`timescale 1ns / 1ps

module gda_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gda_pkg::sts_t sts,
  output gda_pkg::cmd_t cmd
);

  gda_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == gda_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gda_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gda_pkg::ST_LEAP;
      end
      gda_pkg::ST_LEAP: begin
        state_nxt = gda_pkg::ST_CHECK;
      end
      gda_pkg::ST_CHECK: begin
        state_nxt = sts.reject ? gda_pkg::ST_DONE : gda_pkg::ST_STEP;
      end
      gda_pkg::ST_STEP: begin
        if (sts.step_final) state_nxt = gda_pkg::ST_DONE;
      end
      gda_pkg::ST_DONE: begin
        if (out_free) state_nxt = gda_pkg::ST_IDLE;
      end
      default: state_nxt = gda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      gda_pkg::ST_IDLE:  cmd.load = in_valid;
      gda_pkg::ST_LEAP:  cmd = '0;
      gda_pkg::ST_CHECK: cmd.check = 1'b1;
      gda_pkg::ST_STEP:  cmd.step = 1'b1;
      gda_pkg::ST_DONE:  cmd.publish = out_free;
      default:           cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.publish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // never overwrite a result that is still waiting
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result published over a pending one");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.check, cmd.step, cmd.publish}))
    else $error("more than one datapath command");

  // a publish always leaves a valid result behind
  a_publish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r)
    else $error("published result not shown");

endmodule

@@ design/gda_dp.sv @@
`timescale 1ns / 1ps

module gda_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  gda_pkg::cmd_t cmd,
  output gda_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_data,
  input  logic [4:0]    day_in,
  input  logic [3:0]    month_in,
  input  logic [13:0]   year_in,
  input  logic [8:0]    days_to_add,
  output logic [4:0]    day_out,
  output logic [3:0]    month_out,
  output logic [13:0]   year_out,
  output logic [1:0]    status
);

  // 25 * INV25 == 1 mod 2**14, so y is a multiple of 25 iff y * INV25 mod 2**14 <= DIV25_LIM
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_LIM = 14'd655;

  logic [8:0]  max_days_r;
  logic [4:0]  dd_r, dd_nxt;
  logic [3:0]  mm_r, mm_nxt;
  logic [13:0] yy_r, yy_nxt;
  logic [8:0]  x_r, x_nxt;
  logic        leap_r;
  gda_pkg::stat_t stat_r;
  logic [4:0]  dout_r;
  logic [3:0]  mout_r;
  logic [13:0] yout_r;
  logic [1:0]  sout_r;

  logic [27:0] prod;
  logic        div25, leap_cur;
  logic [4:0]  len;
  logic [4:0]  room;
  logic        over_limit, bad_date, fits;

  assign prod     = {14'd0, yy_r} * {14'd0, INV25};
  assign div25    = (prod[13:0] <= DIV25_LIM);
  assign leap_cur = (yy_r[1:0] == 2'd0) && (!div25 || yy_r[3:0] == 4'd0);

  assign len        = gda_pkg::month_len(mm_r, leap_r);
  assign room       = len - dd_r;
  assign over_limit = (x_r > max_days_r);
  assign bad_date   = (mm_r == 4'd0) || (mm_r > gda_pkg::MONTHS_PER_YEAR) ||
                      (dd_r == 5'd0) || (dd_r > len);
  assign fits       = (x_r <= {4'd0, room});

  assign sts.reject     = over_limit || bad_date;
  assign sts.step_final = fits;

  always_comb begin
    dd_nxt = dd_r;
    mm_nxt = mm_r;
    yy_nxt = yy_r;
    x_nxt  = x_r;
    if (cmd.load) begin
      dd_nxt = day_in;
      mm_nxt = month_in;
      yy_nxt = year_in;
      x_nxt  = days_to_add;
    end else if (cmd.step) begin
      if (fits) begin
        dd_nxt = dd_r + x_r[4:0];
        x_nxt  = 9'd0;
      end else begin
        // jump to the first of the next month
        x_nxt  = x_r - {4'd0, room} - 9'd1;
        dd_nxt = 5'd1;
        if (mm_r == gda_pkg::MONTHS_PER_YEAR) begin
          mm_nxt = 4'd1;
          yy_nxt = yy_r + 14'd1;
        end else begin
          mm_nxt = mm_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_days_r <= gda_pkg::MAX_DAYS_RESET;
    end else if (cfg_we) begin
      max_days_r <= cfg_data;
    end
  end

  // leap flag is registered from the year, so it trails a year change; january never needs it
  always_ff @(posedge clk) begin
    dd_r   <= dd_nxt;
    mm_r   <= mm_nxt;
    yy_r   <= yy_nxt;
    x_r    <= x_nxt;
    leap_r <= leap_cur;
    if (cmd.check) begin
      if (over_limit) begin
        stat_r <= gda_pkg::STAT_TOO_MANY;
      end else if (bad_date) begin
        stat_r <= gda_pkg::STAT_BAD_DATE;
      end else begin
        stat_r <= gda_pkg::STAT_OK;
      end
    end
    if (cmd.publish) begin
      if (stat_r == gda_pkg::STAT_OK) begin
        dout_r <= dd_r;
        mout_r <= mm_r;
        yout_r <= yy_r;
      end else begin
        dout_r <= 5'd0;
        mout_r <= 4'd0;
        yout_r <= 14'd0;
      end
      sout_r <= stat_r;
    end
  end

  assign day_out   = dout_r;
  assign month_out = mout_r;
  assign year_out  = yout_r;
  assign status    = sout_r;

  // a month step always lands on a real calendar position
  a_step_sane: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.step) && !$past(fits) |-> (dd_r == 5'd1 && mm_r >= 4'd1 &&
      mm_r <= gda_pkg::MONTHS_PER_YEAR))
    else $error("month step left an invalid date");

endmodule

@@ design/gregorian_date_add_days_unit.sv @@
`timescale 1ns / 1ps
// an input transfer goes through LEAP and CHECK; a rejected item then goes to DONE,
// an accepted one first runs the STEP loop until the remaining days fit in the month
// a new item is taken only in IDLE, after DONE has published the result; the month-step loop
// of the datapath advances one calendar month per cycle
// reset (rst_n low, synchronous): idle, no result pending, max_days = 300

module gregorian_date_add_days_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_day_in,
  input  logic [3:0]  in_month_in,
  input  logic [13:0] in_year_in,
  input  logic [8:0]  in_days_to_add,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_day_out,
  output logic [3:0]  out_month_out,
  output logic [13:0] out_year_out,
  output logic [1:0]  out_status
);

  gda_pkg::cmd_t cmd;
  gda_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gda_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .day_in      (in_day_in),
    .month_in    (in_month_in),
    .year_in     (in_year_in),
    .days_to_add (in_days_to_add),
    .day_out     (out_day_out),
    .month_out   (out_month_out),
    .year_out    (out_year_out),
    .status      (out_status)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [8:0]  count;
  } date_req_t;

  typedef struct packed {
    logic [4:0]      day;
    logic [3:0]      month;
    logic [13:0]     year;
    gda_pkg::stat_t  status;
  } date_result_t;

  typedef struct packed {
    date_req_t    req;
    logic         literal;
    date_result_t known;
  } date_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  in_day_in;
  logic [3:0]  in_month_in;
  logic [13:0] in_year_in;
  logic [8:0]  in_days_to_add;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_day_out;
  logic [3:0]  out_month_out;
  logic [13:0] out_year_out;
  logic [1:0]  out_status;

  date_result_t pending_dates [$];
  logic [8:0]   max_days_model;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;

  // rows with literal set carry a result that can be read off directly
  date_row_t directed_rows [21] = '{
    '{'{5'd1,  4'd1,  14'd2000,  9'd0},   1'b1, '{5'd1,  4'd1, 14'd2000, gda_pkg::STAT_OK}},
    '{'{5'd15, 4'd6,  14'd2023,  9'd301}, 1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_TOO_MANY}},
    '{'{5'd31, 4'd15, 14'd16383, 9'd511}, 1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_TOO_MANY}},
    '{'{5'd0,  4'd3,  14'd2023,  9'd5},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd5,  4'd0,  14'd2023,  9'd5},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd5,  4'd13, 14'd2023,  9'd5},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd5,  4'd15, 14'd16383, 9'd5},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd29, 4'd2,  14'd2023,  9'd1},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd29, 4'd2,  14'd1900,  9'd0},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd29, 4'd2,  14'd2000,  9'd0},   1'b1, '{5'd29, 4'd2, 14'd2000, gda_pkg::STAT_OK}},
    '{'{5'd31, 4'd4,  14'd2023,  9'd0},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd0,  4'd0,  14'd0,     9'd0},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd31, 4'd2,  14'd2024,  9'd0},   1'b1, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_BAD_DATE}},
    '{'{5'd31, 4'd1,  14'd2023,  9'd300}, 1'b0, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_OK}},
    '{'{5'd29, 4'd2,  14'd2024,  9'd1},   1'b0, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_OK}},
    '{'{5'd31, 4'd12, 14'd16383, 9'd1},   1'b0, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_OK}},
    '{'{5'd1,  4'd1,  14'd0,     9'd300}, 1'b0, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_OK}},
    '{'{5'd28, 4'd2,  14'd2100,  9'd1},   1'b0, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_OK}},
    '{'{5'd30, 4'd6,  14'd2023,  9'd300}, 1'b0, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_OK}},
    '{'{5'd31, 4'd12, 14'd9999,  9'd300}, 1'b0, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_OK}},
    '{'{5'd1,  4'd3,  14'd2024,  9'd300}, 1'b0, '{5'd0, 4'd0, 14'd0, gda_pkg::STAT_OK}}
  };

  gregorian_date_add_days_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_day_in      (in_day_in),
    .in_month_in    (in_month_in),
    .in_year_in     (in_year_in),
    .in_days_to_add (in_days_to_add),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_day_out    (out_day_out),
    .out_month_out  (out_month_out),
    .out_year_out   (out_year_out),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit leap_year(int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 400 == 0) return 1'b1;
    return (y % 100) != 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && leap_year(y)) return 29;
    return lengths[m - 1];
  endfunction

  function automatic date_result_t advance_date(date_req_t r, logic [8:0] limit);
    date_result_t res;
    int unsigned  d;
    int unsigned  m;
    int unsigned  y;
    int unsigned  left;
    int unsigned  room;
    d = r.day;
    m = r.month;
    y = r.year;
    left = r.count;
    res = '{day: 5'd0, month: 4'd0, year: 14'd0, status: gda_pkg::STAT_OK};
    if (left > limit) begin
      res.status = gda_pkg::STAT_TOO_MANY;
    end else if (m < 1 || m > 12 || d < 1 || d > days_in_month(m, y)) begin
      res.status = gda_pkg::STAT_BAD_DATE;
    end else begin
      // one calendar month per pass, year carried past 14 bits then cut
      while (left > 0) begin
        room = days_in_month(m, y) - d;
        if (left <= room) begin
          d += left;
          left = 0;
        end else begin
          left -= room + 1;
          d = 1;
          m++;
          if (m > 12) begin
            m = 1;
            y++;
          end
        end
      end
      res.day = 5'(d);
      res.month = 4'(m);
      res.year = 14'(y);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    end
  endtask

  task automatic make_request(output date_req_t r, input logic [8:0] limit);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 78) begin
      r.month = 4'($urandom_range(1, 12));
      case ($urandom_range(19)) inside
        0, 1, 2:  r.year = 14'($urandom_range(0, 163) * 100);
        3, 4:     r.year = 14'($urandom_range(16380, 16383));
        5, 6, 7:  r.year = 14'($urandom_range(1896, 2104));
        default:  r.year = 14'($urandom);
      endcase
      // month ends are where the stepping gets interesting
      if ($urandom_range(3) == 0) begin
        r.day = 5'(days_in_month(r.month, r.year));
      end else begin
        r.day = 5'($urandom_range(1, days_in_month(r.month, r.year)));
      end
      case ($urandom_range(19)) inside
        0, 1:     r.count = 9'd0;
        2, 3, 4:  r.count = limit;
        5, 6:     r.count = 9'($urandom);
        default:  r.count = 9'($urandom_range(0, limit));
      endcase
    end else begin
      r.day = 5'($urandom);
      r.month = 4'($urandom);
      r.year = 14'($urandom);
      r.count = 9'($urandom);
    end
  endtask

  task automatic send_request(input date_req_t r, input date_result_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_day_in <= r.day;
    in_month_in <= r.month;
    in_year_in <= r.year;
    in_days_to_add <= r.count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_dates.push_back(want);
  endtask

  // drop valid and hold off until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_days(input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_days_model = value;
  endtask

  always @(posedge clk) begin
    out_ready <= !($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    date_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result transfer with nothing pending, status", out_status, 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_day_out !== want.day) report_mismatch("day_out", out_day_out, want.day);
        if (out_month_out !== want.month) begin
          report_mismatch("month_out", out_month_out, want.month);
        end
        if (out_year_out !== want.year) report_mismatch("year_out", out_year_out, want.year);
        if (out_status !== want.status) begin
          report_mismatch("status", out_status, int'(want.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    date_req_t   req;
    date_result_t want;
    logic [8:0]  limit;
    int          items;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_day_in <= '0;
    in_month_in <= '0;
    in_year_in <= '0;
    in_days_to_add <= '0;
    max_days_model = 9'd300;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      want = directed_rows[i].literal ? directed_rows[i].known
                                      : advance_date(directed_rows[i].req, max_days_model);
      send_request(directed_rows[i].req, want);
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          limit = 9'd511;
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          items = 110;
        end
        1: begin
          limit = 9'd0;
          sender_idle_pct = 73;
          receiver_stall_pct = 0;
          items = 40;
        end
        2: begin
          limit = 9'($urandom_range(1, 510));
          sender_idle_pct = 0;
          receiver_stall_pct = 73;
          items = 120;
        end
        3: begin
          limit = 9'd300;
          sender_idle_pct = 38;
          receiver_stall_pct = 38;
          items = 120;
        end
        default: begin
          limit = 9'($urandom_range(0, 511));
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          items = 100;
        end
      endcase
      settle();
      write_max_days(limit);
      for (int n = 0; n < items; n++) begin
        if (n % 40 == 39) settle();
        make_request(req, max_days_model);
        send_request(req, advance_date(req, max_days_model));
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
